// ----- rtl/ffpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared widths, request kinds, result codes and register indexes of the
// first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int ADDR_W   = 64;
  localparam int COUNT_W  = 13;
  localparam int KIND_W   = 2;
  localparam int CODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam kind_t KIND_INIT  = 2'd0;
  localparam kind_t KIND_ALLOC = 2'd1;
  localparam kind_t KIND_FREE  = 2'd2;

  localparam code_t CODE_OK     = 2'd0;
  localparam code_t CODE_NO_FIT = 2'd1;
  localparam code_t CODE_ZERO   = 2'd2;
  localparam code_t CODE_RANGE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 2'd2;

endpackage

// ----- rtl/ffpa_page_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_page_map
// One taken bit per page: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffpa_page_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];
  logic rd_bit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

// ----- rtl/first_fit_page_allocator_top.sv -----
`timescale 1ns / 1ps
// Request handling: init rewrites every page-map entry; allocate scans one page per cycle from page 0,
//   then marks the run; free checks the range, then clears its pages; zero count, out-of-range free
//   and unknown kind go straight to the result without touching the page map.
// Throughput: one request at a time; the next is accepted once the result is registered.
// Reset: a clearing pass writes every page-map entry free with in_tready low; config writes are
//   taken throughout.
// ----------------------------------------------------------------------------
// first_fit_page_allocator_top
// First-fit contiguous page allocator over a bit-per-page map held in RAM.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_top #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ffpa_pkg::IN_TDATA_W-1:0]    in_tdata,  // page_address[63:0], page_count[76:64]
  input  logic [ffpa_pkg::KIND_W-1:0]        in_tuser,  // kind[1:0]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ffpa_pkg::OUT_TDATA_W-1:0]   out_tdata, // run_address[63:0], result_code[65:64],
                                                        // pages_in_use[78:66]
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW  = $clog2(MAX_PAGES);
  localparam int CW  = (IW + 1 > ffpa_pkg::COUNT_W) ? IW + 1 : ffpa_pkg::COUNT_W;
  localparam int AW  = ffpa_pkg::ADDR_W;
  localparam int NW  = ffpa_pkg::COUNT_W;
  localparam int HIW = AW - PAGE_SHIFT - CW;

  localparam logic [CW-1:0] MAX_PAGES_C = CW'(MAX_PAGES);
  localparam logic [CW-1:0] LAST_PAGE_C = CW'(MAX_PAGES - 1);

  localparam logic [2:0] S_SWEEP  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_FCHK   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_MARK   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // configuration
  logic [AW-1:0] base_r;
  logic [NW-1:0] total_r, reserved_r;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic          reply_r, reply_nxt;
  logic [NW-1:0] used_r, used_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] ev_r, ev_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] streak_r, streak_nxt;

  // payload
  ffpa_pkg::kind_t kind_r;
  logic [AW-1:0]   addr_r;
  logic [NW-1:0]   num_r;
  logic [AW:0]     diff_r, diff_nxt;
  ffpa_pkg::code_t code_r, code_nxt;
  logic [CW-1:0]   first_r, first_nxt;
  logic            alloc_ok_r, alloc_ok_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            wval_r, wval_nxt;
  logic [AW-1:0]   out_addr_r, out_addr_nxt;
  ffpa_pkg::code_t out_code_r, out_code_nxt;
  logic [NW-1:0]   out_used_r, out_used_nxt;

  // helpers
  logic [CW-1:0]   size;
  logic [CW-1:0]   num_ext;
  logic [CW-1:0]   res_ext;
  logic [CW-1:0]   idx_lo;
  logic [HIW-1:0]  idx_hi;
  logic [CW-1:0]   streak_inc;
  logic [NW:0]     used_sum;
  logic            out_load;

  // page map port
  logic          map_we, map_wbit, map_re, map_rbit;
  logic [IW-1:0] map_waddr, map_raddr;

  ffpa_page_map #(
    .DEPTH (MAX_PAGES),
    .AW    (IW)
  ) u_page_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_bit  (map_wbit),
    .rd_en   (map_re),
    .rd_addr (map_raddr),
    .rd_bit  (map_rbit)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_used_r, out_code_r, out_addr_r};

  assign size    = (CW'(total_r) > MAX_PAGES_C) ? MAX_PAGES_C : CW'(total_r);
  assign num_ext = CW'(num_r);
  assign res_ext = CW'(reserved_r);
  assign idx_lo  = diff_r[PAGE_SHIFT+CW-1:PAGE_SHIFT];
  assign idx_hi  = diff_r[AW-1:PAGE_SHIFT+CW];
  assign streak_inc = map_rbit ? '0 : streak_r + CW'(1);
  assign used_sum   = {1'b0, used_r} + {1'b0, num_r};
  assign out_load   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      total_r    <= NW'(4096);
      reserved_r <= NW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffpa_pkg::CFG_REGION_BASE:    base_r     <= cfg_data;
        ffpa_pkg::CFG_TOTAL_PAGES:    total_r    <= cfg_data[NW-1:0];
        ffpa_pkg::CFG_RESERVED_PAGES: reserved_r <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    lim_nxt       = lim_r;
    reply_nxt     = reply_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    ev_nxt        = ev_r;
    pend_nxt      = pend_r;
    streak_nxt    = streak_r;
    diff_nxt      = diff_r;
    code_nxt      = code_r;
    first_nxt     = first_r;
    alloc_ok_nxt  = alloc_ok_r;
    cnt_nxt       = cnt_r;
    wval_nxt      = wval_r;
    out_addr_nxt  = out_addr_r;
    out_code_nxt  = out_code_r;
    out_used_nxt  = out_used_r;
    out_valid_nxt = out_valid_r && !out_tready;
    map_we        = 1'b0;
    map_waddr     = ptr_r[IW-1:0];
    map_wbit      = wval_r;
    map_re        = 1'b0;
    map_raddr     = scan_r[IW-1:0];

    case (state_r)
      S_SWEEP: begin
        // clears after reset; on init marks the leading reserved pages
        map_we   = 1'b1;
        map_wbit = (ptr_r < lim_r);
        ptr_nxt  = ptr_r + CW'(1);
        if (ptr_r == LAST_PAGE_C) begin
          if (reply_r) begin
            used_nxt  = '0;
            code_nxt  = ffpa_pkg::CODE_OK;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        // item is registered by the payload block below
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        alloc_ok_nxt = 1'b0;
        code_nxt     = ffpa_pkg::CODE_OK;
        case (kind_r)
          ffpa_pkg::KIND_INIT: begin
            lim_nxt   = (res_ext < size) ? res_ext : size;
            ptr_nxt   = '0;
            reply_nxt = 1'b1;
            state_nxt = S_SWEEP;
          end
          ffpa_pkg::KIND_ALLOC: begin
            if (num_r == '0) begin
              code_nxt  = ffpa_pkg::CODE_ZERO;
              state_nxt = S_RESULT;
            end else begin
              scan_nxt   = '0;
              streak_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          ffpa_pkg::KIND_FREE: begin
            if (num_r == '0) begin
              code_nxt  = ffpa_pkg::CODE_ZERO;
              state_nxt = S_RESULT;
            end else begin
              diff_nxt  = {1'b0, addr_r} - {1'b0, base_r};
              state_nxt = S_FCHK;
            end
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_FCHK: begin
        if (diff_r[AW] || (idx_hi != '0) || (idx_lo >= size) ||
            (num_ext > size - idx_lo)) begin
          code_nxt  = ffpa_pkg::CODE_RANGE;
          state_nxt = S_RESULT;
        end else begin
          ptr_nxt   = idx_lo;
          cnt_nxt   = num_r;
          wval_nxt  = 1'b0;
          state_nxt = S_MARK;
        end
      end
      S_SCAN: begin
        // read of scan_r issued each cycle, its bit checked the next
        if (pend_r && (streak_inc == num_ext)) begin
          first_nxt = ev_r + CW'(1) - num_ext;
          ptr_nxt   = ev_r + CW'(1) - num_ext;
          cnt_nxt   = num_r;
          wval_nxt  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_MARK;
        end else begin
          if (pend_r) begin
            streak_nxt = streak_inc;
          end
          if (scan_r < size) begin
            map_re   = 1'b1;
            ev_nxt   = scan_r;
            scan_nxt = scan_r + CW'(1);
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              code_nxt  = ffpa_pkg::CODE_NO_FIT;
              state_nxt = S_RESULT;
            end
          end
        end
      end
      S_MARK: begin
        map_we  = 1'b1;
        ptr_nxt = ptr_r + CW'(1);
        cnt_nxt = cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          if (wval_r) begin
            used_nxt     = (used_sum > {1'b0, ffpa_pkg::COUNT_MAX}) ?
                           ffpa_pkg::COUNT_MAX : used_sum[NW-1:0];
            alloc_ok_nxt = 1'b1;
          end else begin
            used_nxt = (used_r > num_r) ? used_r - num_r : '0;
          end
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          out_addr_nxt  = alloc_ok_r ?
                          base_r + (AW'(first_r) << PAGE_SHIFT) : '0;
          out_code_nxt  = code_r;
          out_used_nxt  = used_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ptr_r       <= '0;
      lim_r       <= '0;
      reply_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      ev_r        <= '0;
      pend_r      <= 1'b0;
      streak_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      lim_r       <= lim_nxt;
      reply_r     <= reply_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      ev_r        <= ev_nxt;
      pend_r      <= pend_nxt;
      streak_r    <= streak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      addr_r <= in_tdata[AW-1:0];
      num_r  <= in_tdata[AW+NW-1:AW];
    end
    diff_r     <= diff_nxt;
    code_r     <= code_nxt;
    first_r    <= first_nxt;
    alloc_ok_r <= alloc_ok_nxt;
    cnt_r      <= cnt_nxt;
    wval_r     <= wval_nxt;
    out_addr_r <= out_addr_nxt;
    out_code_r <= out_code_nxt;
    out_used_r <= out_used_nxt;
  end

endmodule

// ----- test/tb_first_fit_page_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_allocator_top
// Self-checking bench for the first-fit page allocator. A clocked driver sends
// init, allocate and free requests from a queue, a shadow page map predicts
// every response, and a clocked monitor compares each result beat field by
// field. Directed corner cases come first, then random traffic over small
// regions under three stall mixes.
// ----------------------------------------------------------------------------
module tb_first_fit_page_allocator_top;

  localparam int PAGES       = 4096;
  localparam int SHIFT       = 12;
  localparam int STALL_LIMIT = 40000;

  localparam ffpa_pkg::kind_t KIND_UNUSED = 2'd3;

  typedef logic [ffpa_pkg::ADDR_W-1:0]  addr_t;
  typedef logic [ffpa_pkg::COUNT_W-1:0] count_t;

  typedef struct packed {
    ffpa_pkg::kind_t kind;
    addr_t           page_address;
    count_t          page_count;
    logic            drain_first;
  } page_req_t;

  typedef struct packed {
    addr_t           run_address;
    ffpa_pkg::code_t result_code;
    count_t          pages_in_use;
  } page_rsp_t;

  logic                               clk;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [ffpa_pkg::IN_TDATA_W-1:0]    in_tdata   = '0;
  logic [ffpa_pkg::KIND_W-1:0]        in_tuser   = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [ffpa_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic                               cfg_valid  = 1'b0;
  logic                               cfg_ready;
  logic [ffpa_pkg::CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [ffpa_pkg::CFG_DATA_W-1:0]    cfg_data   = '0;

  // shadow of the block's registers and page map
  addr_t     region_base_q    = '0;
  count_t    total_pages_q    = 13'd4096;
  count_t    reserved_pages_q = 13'd1;
  bit        taken_map [PAGES];
  count_t    pages_used       = '0;

  page_req_t req_queue[$];
  page_rsp_t awaited_rsp[$];
  page_req_t req_on_bus;
  page_rsp_t want_rsp;
  page_rsp_t got_rsp;

  int send_idle   = 22;
  int recv_idle   = 46;
  int in_flight   = 0;
  int idle_cycles = 0;
  int err_count   = 0;

  first_fit_page_allocator_top #(
    .MAX_PAGES (PAGES),
    .PAGE_SHIFT(SHIFT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // page_address[63:0], page_count[76:64]
    .in_tuser  (in_tuser),   // kind[1:0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // run_address[63:0], result_code[65:64], pages_in_use[78:66]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // applies one request to the shadow map and returns the response it yields
  function automatic page_rsp_t serve_request(page_req_t r);
    int unsigned span, keep, streak, first, i;
    addr_t       page_idx;
    logic [ffpa_pkg::COUNT_W:0] sum;
    logic        hit;
    page_rsp_t   rsp;
    span = (total_pages_q < PAGES) ? total_pages_q : PAGES;
    rsp.run_address = '0;
    rsp.result_code = ffpa_pkg::CODE_OK;
    case (r.kind)
      ffpa_pkg::KIND_INIT: begin
        keep = (reserved_pages_q < span) ? reserved_pages_q : span;
        for (i = 0; i < PAGES; i++) taken_map[i] = (i < keep);
        pages_used = '0;
      end
      ffpa_pkg::KIND_ALLOC: begin
        if (r.page_count == 0) begin
          rsp.result_code = ffpa_pkg::CODE_ZERO;
        end else begin
          streak = 0;
          first  = 0;
          hit    = 1'b0;
          for (i = 0; i < span && !hit; i++) begin
            if (taken_map[i]) begin
              streak = 0;
            end else begin
              streak++;
              if (streak == r.page_count) begin
                first = i + 1 - r.page_count;
                hit   = 1'b1;
              end
            end
          end
          if (!hit) begin
            rsp.result_code = ffpa_pkg::CODE_NO_FIT;
          end else begin
            for (i = first; i < first + r.page_count; i++) taken_map[i] = 1'b1;
            sum = pages_used + r.page_count;
            pages_used = (sum > ffpa_pkg::COUNT_MAX) ? ffpa_pkg::COUNT_MAX :
                         sum[ffpa_pkg::COUNT_W-1:0];
            // wraps modulo 2^64 on purpose
            rsp.run_address = region_base_q + (addr_t'(first) << SHIFT);
          end
        end
      end
      ffpa_pkg::KIND_FREE: begin
        if (r.page_count == 0) begin
          rsp.result_code = ffpa_pkg::CODE_ZERO;
        end else if (r.page_address < region_base_q) begin
          rsp.result_code = ffpa_pkg::CODE_RANGE;
        end else begin
          page_idx = (r.page_address - region_base_q) >> SHIFT;
          if (page_idx >= span || r.page_count > span - page_idx) begin
            rsp.result_code = ffpa_pkg::CODE_RANGE;
          end else begin
            for (i = page_idx[31:0]; i < page_idx + r.page_count; i++) taken_map[i] = 1'b0;
            pages_used = (pages_used > r.page_count) ? pages_used - r.page_count : '0;
          end
        end
      end
      default: ;  // unknown kind leaves everything alone
    endcase
    rsp.pages_in_use = pages_used;
    return rsp;
  endfunction

  function automatic addr_t page_addr(addr_t base, int unsigned idx);
    return base + (addr_t'(idx) << SHIFT);
  endfunction

  // request driver
  always @(posedge clk) begin : req_drive
    int        flight;
    page_req_t head;
    flight = in_flight;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_rsp.push_back(serve_request(req_on_bus));
        flight++;
      end
      if (out_tvalid && out_tready) flight--;
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() != 0) head = req_queue[0];
        if (req_queue.size() != 0 && !(head.drain_first && flight != 0) &&
            $urandom_range(99) >= send_idle) begin
          req_on_bus = req_queue.pop_front();
          in_tdata   <= {{(ffpa_pkg::IN_TDATA_W-ffpa_pkg::ADDR_W-ffpa_pkg::COUNT_W){1'b0}},
                         req_on_bus.page_count, req_on_bus.page_address};
          in_tuser   <= req_on_bus.kind;
          in_tvalid  <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      in_flight <= flight;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_rsp.run_address  = out_tdata[ffpa_pkg::ADDR_W-1:0];
        got_rsp.result_code  = out_tdata[ffpa_pkg::ADDR_W +: ffpa_pkg::CODE_W];
        got_rsp.pages_in_use = out_tdata[ffpa_pkg::ADDR_W+ffpa_pkg::CODE_W +: ffpa_pkg::COUNT_W];
        if (awaited_rsp.size() == 0) begin
          err_count++;
          $display("%0t: result beat with no request outstanding, got %h", $time, out_tdata);
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (got_rsp.run_address !== want_rsp.run_address) begin
            err_count++;
            $display("%0t: run_address expected %h got %h", $time,
                     want_rsp.run_address, got_rsp.run_address);
          end
          if (got_rsp.result_code !== want_rsp.result_code) begin
            err_count++;
            $display("%0t: result_code expected %0d got %0d", $time,
                     want_rsp.result_code, got_rsp.result_code);
          end
          if (got_rsp.pages_in_use !== want_rsp.pages_in_use) begin
            err_count++;
            $display("%0t: pages_in_use expected %0d got %0d", $time,
                     want_rsp.pages_in_use, got_rsp.pages_in_use);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // register mirror
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffpa_pkg::CFG_REGION_BASE:    region_base_q    <= cfg_data;
        ffpa_pkg::CFG_TOTAL_PAGES:    total_pages_q    <= cfg_data[ffpa_pkg::COUNT_W-1:0];
        ffpa_pkg::CFG_RESERVED_PAGES: reserved_pages_q <= cfg_data[ffpa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // watchdog: no beat on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("** first_fit_page_allocator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [ffpa_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [ffpa_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input addr_t base, input int unsigned total,
                           input int unsigned reserved);
    write_reg(ffpa_pkg::CFG_REGION_BASE, base);
    write_reg(ffpa_pkg::CFG_TOTAL_PAGES, addr_t'(total));
    write_reg(ffpa_pkg::CFG_RESERVED_PAGES, addr_t'(reserved));
    @(negedge clk);
  endtask

  task automatic push_req(input ffpa_pkg::kind_t kind, input addr_t addr,
                          input int unsigned num, input logic drain);
    page_req_t r;
    r.kind         = kind;
    r.page_address = addr;
    r.page_count   = count_t'(num);
    r.drain_first  = drain;
    req_queue.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (req_queue.size() != 0 || in_tvalid || in_flight != 0);
  endtask

  // small region, mostly plausible allocs and frees inside it
  task automatic random_phase(input int n_items);
    int unsigned span, pick, k;
    addr_t       base;
    page_req_t   r;
    span = $urandom_range(4, 48);
    base = {$urandom, $urandom};
    if ($urandom_range(1)) base[SHIFT-1:0] = '0;
    configure(base, span, $urandom_range(0, span / 2));
    push_req(ffpa_pkg::KIND_INIT, '0, 0, 1'b0);
    for (k = 0; k < n_items; k++) begin
      r.page_address = {$urandom, $urandom};
      r.page_count   = count_t'($urandom_range(1, 6));
      r.drain_first  = ($urandom_range(19) == 0);
      pick = $urandom_range(99);
      if (pick < 45) begin
        r.kind = ffpa_pkg::KIND_ALLOC;
      end else if (pick < 82) begin
        r.kind = ffpa_pkg::KIND_FREE;
        r.page_address = page_addr(base, $urandom_range(0, span - 1)) +
                         addr_t'($urandom_range(0, (1 << SHIFT) - 1));
        r.page_count = count_t'($urandom_range(1, 4));
      end else if (pick < 88) begin
        r.kind = ffpa_pkg::KIND_FREE;
        r.page_count = count_t'($urandom_range(0, PAGES));
      end else if (pick < 94) begin
        r.kind = ffpa_pkg::KIND_ALLOC;
        r.page_count = count_t'($urandom_range(0, span + 2));
      end else if (pick < 97) begin
        r.kind = KIND_UNUSED;
      end else begin
        r.kind = ffpa_pkg::KIND_INIT;
      end
      req_queue.push_back(r);
    end
  endtask

  initial begin : stimulus
    addr_t b1, b2;
    b1 = 64'h0000_0000_8000_0000;
    b2 = 64'hFFFF_FFFF_FFFF_E000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // full region, one reserved page
    configure(b1, PAGES, 1);
    push_req(ffpa_pkg::KIND_INIT,   '0, 0, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC,  '0, 0, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   b1, 0, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC,  '0, 1, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC,  '0, PAGES, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC,  '0, PAGES - 2, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC,  '0, 1, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   page_addr(b1, 2) + 64'h123, PAGES - 2, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   b1 - 1, 1, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   page_addr(b1, PAGES), 1, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   page_addr(b1, PAGES - 1), 2, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   page_addr(b1, PAGES - 1), 1, 1'b1);
    push_req(ffpa_pkg::KIND_FREE,   page_addr(b1, PAGES - 1), 1, 1'b0);
    push_req(KIND_UNUSED,           '1, PAGES, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,   '1, PAGES, 1'b0);
    wait_idle();

    // oversized region and reservation, base near the top of the address space
    configure(b2, 8191, 8191);
    push_req(ffpa_pkg::KIND_INIT,  '0, 0, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC, '0, 1, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,  b2, PAGES, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC, '0, 3, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC, '0, 3, 1'b0);
    wait_idle();

    // empty region
    configure('0, 0, 0);
    push_req(ffpa_pkg::KIND_ALLOC, '0, 1, 1'b0);
    push_req(ffpa_pkg::KIND_FREE,  '0, 1, 1'b0);
    push_req(ffpa_pkg::KIND_INIT,  '0, 0, 1'b0);
    wait_idle();

    // single page region
    configure('0, 1, 0);
    push_req(ffpa_pkg::KIND_ALLOC, '0, 1, 1'b0);
    push_req(ffpa_pkg::KIND_ALLOC, '0, 1, 1'b0);
    wait_idle();

    random_phase(35);
    wait_idle();
    send_idle = 46;
    recv_idle = 22;
    random_phase(35);
    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    random_phase(40);
    wait_idle();

    repeat (20) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, awaited_rsp.size());
    end
    if (err_count == 0) begin
      $display("** first_fit_page_allocator_top: PASSED **");
    end else begin
      $display("** first_fit_page_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ffpa_pkg.sv
rtl/ffpa_page_map.sv
rtl/first_fit_page_allocator_top.sv
test/tb_first_fit_page_allocator_top.sv
